@@ design/ssnce_pkg.sv @@
// Shared types, constants and the digit-to-segment table for the
// seven-segment number command encoder. No dependencies.
`default_nettype none
package ssnce_pkg;

  // Widths of the port fields
  localparam int ValueW  = 15;
  localparam int ByteW   = 8;
  localparam int BrightW = 3;
  localparam int RemW    = 14;
  localparam int Digits  = 4;

  // Display limits in tenths
  localparam logic signed [ValueW-1:0] MaxTenths = 15'sd9999;
  localparam logic signed [ValueW-1:0] MinTenths = -15'sd999;

  // Command bytes sent to the display driver
  localparam logic [ByteW-1:0] CmdFixedAddr = 8'h44;
  localparam logic [ByteW-1:0] CmdAddrBase  = 8'hC0;
  localparam logic [ByteW-1:0] CmdDispCtrl  = 8'h88;
  localparam logic [ByteW-1:0] SegDot       = 8'h80;
  localparam logic [ByteW-1:0] SegMinus     = 8'h40;
  localparam logic [ByteW-1:0] SegBlank     = 8'h00;
  localparam logic [1:0]       DotDigit     = 2'd2;

  // Position of a byte inside one digit's four-byte sequence
  localparam logic [1:0] SubMode = 2'd0;
  localparam logic [1:0] SubAddr = 2'd1;
  localparam logic [1:0] SubData = 2'd2;
  localparam logic [1:0] SubCtrl = 2'd3;

  // Decimal weight of each digit position, most significant first
  localparam logic [RemW-1:0] Place [Digits] = '{14'd1000, 14'd100, 14'd10, 14'd1};

  // Four segment bytes, digit 0 in the lowest byte
  typedef logic [Digits-1:0][ByteW-1:0] seg_word_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Front sequencer states
  typedef enum logic [1:0] {
    FrontIdle,
    FrontConv,
    FrontPush
  } front_state_t;

  // Seven-segment pattern, bit order XGFEDCBA
  function automatic logic [ByteW-1:0] seg_of(input logic [3:0] digit);
    logic [ByteW-1:0] seg;
    case (digit)
      4'd0: seg = 8'h3f;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5b;
      4'd3: seg = 8'h4f;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6d;
      4'd6: seg = 8'h7d;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7f;
      4'd9: seg = 8'h6f;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

@@ design/seven_segment_number_command_encoder_core.sv @@
// m_axis_tvalid rises once a value has passed the front end's conversion
// and push states, the queue and the registered output stage; with
// m_axis_tready high the first byte transfers on the next edge, and the
// sixteen bytes then follow one per cycle while m_axis_tready is high.
// The back-end byte counter sets the value rate; the front end runs
// ahead through a two-entry queue. Reset (rst, synchronous) empties the
// queue, clears the output stage and sets brightness to 7.
`default_nettype none
module seven_segment_number_command_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_wdata,      // brightness
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [14:0] value_tenths, [15] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] command_byte
  output logic [1:0]       m_axis_tuser,   // [0] frame_start, [1] frame_end
  output logic             m_axis_tlast    // last
);
  import ssnce_pkg::*;

  logic [BrightW-1:0] brightness;
  logic               q_push;
  logic               q_pop;
  seg_word_t          q_in;
  seg_word_t          q_out;
  fifo_status_t       q_status;
  logic [1:0]         flags;

  // Brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  ssnce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_value (s_axis_tdata[ValueW-1:0]),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  ssnce_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  ssnce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .brightness (brightness),
    .q_status   (q_status),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_flags  (flags),
    .out_last   (m_axis_tlast)
  );

  // flags carry {end, start}: start in the low tuser bit
  assign m_axis_tuser = flags;

endmodule
`default_nettype wire

@@ design/ssnce_front.sv @@
// Front end: accepts a value in tenths, checks range and sign, and turns
// it into four segment bytes, one digit per cycle. Depends on ssnce_pkg.
`default_nettype none
module ssnce_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ssnce_pkg::ValueW-1:0] in_value,
  input  wire ssnce_pkg::fifo_status_t     q_status,
  output logic                             q_push,
  output ssnce_pkg::seg_word_t             q_data
);
  import ssnce_pkg::*;

  front_state_t state, state_next;
  logic [1:0]      idx;
  logic [RemW-1:0] rem;
  logic            neg;
  logic            ovf;
  seg_word_t       segs;

  logic                     conv_en;
  logic                     take;
  logic signed [ValueW-1:0] v;
  logic [ValueW-1:0]        mag;
  logic [3:0]               digit;
  logic [RemW-1:0]          sub;
  logic [RemW-1:0]          step;
  logic [ByteW-1:0]         seg;

  assign take = in_valid && in_ready;
  assign v    = signed'(in_value);
  assign mag  = v[ValueW-1] ? ValueW'(-v) : ValueW'(v);

  // Digit at the current place: largest k with k*place <= rem
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      step = RemW'(k) * Place[idx];
      if (rem >= step) begin
        digit = 4'(k);
        sub   = step;
      end
    end
  end

  // Segment byte for the digit being converted
  always_comb begin
    if (ovf) begin
      seg = SegBlank;
    end else if (neg && idx == 2'd0) begin
      seg = SegMinus;
    end else begin
      seg = seg_of(digit);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FrontIdle: if (in_valid) state_next = FrontConv;
      FrontConv: if (idx == 2'd3) state_next = FrontPush;
      FrontPush: if (!q_status.full) state_next = FrontIdle;
      default:   state_next = FrontIdle;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    conv_en  = 1'b0;
    q_push   = 1'b0;
    case (state)
      FrontIdle: in_ready = 1'b1;
      FrontConv: conv_en  = 1'b1;
      FrontPush: q_push   = !q_status.full;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FrontIdle;
    end else begin
      state <= state_next;
    end
  end

  // Capture on accept, then peel one digit per cycle
  always_ff @(posedge clk) begin
    if (take) begin
      neg <= v[ValueW-1];
      ovf <= (v > MaxTenths) || (v < MinTenths);
      rem <= ((v > MaxTenths) || (v < MinTenths)) ? '0 : mag[RemW-1:0];
      idx <= 2'd0;
    end else if (conv_en) begin
      segs[idx] <= seg;
      rem       <= rem - sub;
      idx       <= idx + 2'd1;
    end
  end

  assign q_data = segs;

  // Remainder stays below 10000 whenever a digit is converted
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    conv_en |-> rem < RemW'(10000))
    else $error("front remainder out of range");

endmodule
`default_nettype wire

@@ design/ssnce_fifo.sv @@
// Two-entry queue of segment words between the front and back ends.
// Depends on ssnce_pkg.
`default_nettype none
module ssnce_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire ssnce_pkg::seg_word_t    push_data,
  input  wire logic                    pop,
  output ssnce_pkg::seg_word_t         pop_data,
  output ssnce_pkg::fifo_status_t      status
);
  import ssnce_pkg::*;

  seg_word_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign pop_data     = entry[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("queue push while full");

endmodule
`default_nettype wire

@@ design/ssnce_back.sv @@
// Back end: walks the sixteen command bytes of the queue head into a
// registered output stage. Depends on ssnce_pkg.
`default_nettype none
module ssnce_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ssnce_pkg::BrightW-1:0] brightness,
  input  wire ssnce_pkg::fifo_status_t       q_status,
  input  wire ssnce_pkg::seg_word_t          q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ssnce_pkg::ByteW-1:0]        out_byte,
  output logic [1:0]                         out_flags,
  output logic                               out_last
);
  import ssnce_pkg::*;

  logic [3:0]       cnt;
  logic             fire;
  logic [1:0]       dig;
  logic [ByteW-1:0] byte_n;
  logic [1:0]       flags_n;

  assign fire  = !q_status.empty && (!out_valid || out_ready);
  assign q_pop = fire && (cnt == 4'hF);
  assign dig   = cnt[3:2];

  // Byte and framing flags {end, start} for the current count
  always_comb begin
    case (cnt[1:0])
      SubMode: begin
        byte_n  = CmdFixedAddr;
        flags_n = 2'b11;
      end
      SubAddr: begin
        byte_n  = CmdAddrBase | {6'd0, dig};
        flags_n = 2'b01;
      end
      SubData: begin
        byte_n  = (dig == DotDigit) ? (q_data[dig] | SegDot) : q_data[dig];
        flags_n = 2'b10;
      end
      SubCtrl: begin
        byte_n  = CmdDispCtrl + {5'd0, brightness};
        flags_n = 2'b11;
      end
      default: begin
        byte_n  = CmdFixedAddr;
        flags_n = 2'b11;
      end
    endcase
  end

  // Byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if (fire) begin
      cnt <= cnt + 4'd1;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= byte_n;
      out_flags <= flags_n;
      out_last  <= (cnt == 4'hF);
    end
  end

  a_mid_needs_head: assert property (@(posedge clk) disable iff (rst)
    cnt != 4'd0 |-> !q_status.empty)
    else $error("byte counter mid-sequence with empty queue");

  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_flags == 2'b11)
    else $error("last byte not a full frame");

  a_last_ctrl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte[7:3] == CmdDispCtrl[7:3])
    else $error("last byte is not display control");

endmodule
`default_nettype wire
